// File: hw/rtl/mbq_pkg.sv
// Shared types, constants and the microprogram of the multichannel biquad.
// Used by mbq_regs, mbq_seq, mbq_datapath and the top level; depends on nothing.

package mbq_pkg;

    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 24;
    localparam int STATE_W    = 40;
    localparam int ACC_W      = STATE_W + 2;
    localparam int ACTIVE_W   = 4;
    localparam int CH_OUT_W   = 3;
    localparam int STEP_W     = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_COMMIT = 3'd7;

    typedef enum logic [2:0] {
        REG_B0     = 3'd0,
        REG_B1     = 3'd1,
        REG_B2     = 3'd2,
        REG_A1     = 3'd3,
        REG_A2     = 3'd4,
        REG_ACTIVE = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [ACTIVE_W-1:0] active;
        logic [COEF_W-1:0]   a2;
        logic [COEF_W-1:0]   a1;
        logic [COEF_W-1:0]   b2;
        logic [COEF_W-1:0]   b1;
        logic [COEF_W-1:0]   b0;
    } t_cfg;

    typedef enum logic [2:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_sel;

    typedef enum logic [1:0] {
        SRC_IN = 2'd0,  // sample on the input port, same cycle as accept
        SRC_X  = 2'd1,  // latched input sample
        SRC_Y  = 2'd2   // saturated output sample
    } t_mul_src;

    typedef enum logic [1:0] {
        ACC_HOLD    = 2'd0,
        ACC_LOAD    = 2'd1,
        ACC_LOAD_D2 = 2'd2,
        ACC_SUB     = 2'd3
    } t_acc_op;

    typedef enum logic [1:0] {
        COND_NEVER    = 2'd0,
        COND_NO_ITEM  = 2'd1,
        COND_OUT_BUSY = 2'd2
    } t_cond;

    typedef struct packed {
        logic              accept;
        logic              mul_en;
        t_coef_sel         mul_coef;
        t_mul_src          mul_src;
        t_acc_op           acc_op;
        logic              y_en;
        logic              d1_en;
        logic              commit;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic start;
        logic out_busy;
    } t_stat;

    // Microprogram: jump to target when the condition holds, else fall to the next step.
    function automatic t_ctl mbq_ucode(input logic [STEP_W-1:0] step);
        t_ctl w;
        w          = '0;
        w.mul_coef = COEF_B0;
        w.mul_src  = SRC_X;
        w.acc_op   = ACC_HOLD;
        w.cond     = COND_NEVER;
        w.target   = STEP_WAIT;
        unique case (step)
            3'd0: begin
                w.accept   = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_coef = COEF_B0;
                w.mul_src  = SRC_IN;
                w.cond     = COND_NO_ITEM;
                w.target   = STEP_WAIT;
            end
            3'd1: begin
                w.acc_op = ACC_LOAD;
            end
            3'd2: begin
                w.y_en     = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_coef = COEF_B1;
                w.mul_src  = SRC_X;
            end
            3'd3: begin
                w.acc_op   = ACC_LOAD_D2;
                w.mul_en   = 1'b1;
                w.mul_coef = COEF_A1;
                w.mul_src  = SRC_Y;
            end
            3'd4: begin
                w.acc_op   = ACC_SUB;
                w.mul_en   = 1'b1;
                w.mul_coef = COEF_B2;
                w.mul_src  = SRC_X;
            end
            3'd5: begin
                w.d1_en    = 1'b1;
                w.acc_op   = ACC_LOAD;
                w.mul_en   = 1'b1;
                w.mul_coef = COEF_A2;
                w.mul_src  = SRC_Y;
            end
            3'd6: begin
                w.acc_op = ACC_SUB;
            end
            3'd7: begin
                w.commit = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_COMMIT;
            end
        endcase
        return w;
    endfunction

    // Clamp the accumulator to the delay-state range.
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return hi[STATE_W-1:0];
        end else if (v < lo) begin
            return lo[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

endpackage

// File: hw/rtl/multichannel_biquad_df2t.sv
// Multichannel biquad filter (direct form II transposed), top level.
// Depends on mbq_pkg, mbq_regs, mbq_seq and mbq_datapath.

// Interleaved samples enter on the slave stream (tuser = 0 filters one sample, tuser = 1
// clears every channel's delay state and the channel position and gives no result). Each
// filtered sample runs an eight-step microprogram that drives one 32-bit by SAMPLE_WIDTH
// multiplier through the five coefficient products; the next item is taken once the result
// has moved into the output register. If that register is still held by the downstream side
// at the last step, the sequencer waits there. A clear item is handled without leaving the
// wait step. Delay state lives in a per-channel memory with valid bits, so reset and clear
// act at once with no clearing pass. The user must write coefficients and channel count over
// the APB-style port only while the block is idle; the block itself does not enforce this.

module multichannel_biquad_df2t import mbq_pkg::*; #(
    parameter  int CHANNELS     = 8,
    parameter  int SAMPLE_WIDTH = 24,
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [TDATA_W-1:0]    i_s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
    input  logic                  i_s_axis_tuser,   // [0] action
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [TDATA_W-1:0]    o_m_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
    output logic [CH_OUT_W-1:0]   o_m_axis_tuser    // [2:0] channel
);

    t_cfg  cfg;
    t_ctl  ctl;
    t_stat stat;

    mbq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    mbq_datapath #(
        .CHANNELS     (CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    a_filter_leaves_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser) |=> !o_s_axis_tready)
        else $error("sequencer did not leave the wait step after a filter item");

    a_clear_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser) |=> o_s_axis_tready)
        else $error("clear item started the filter program");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(ctl.commit))
        else $error("result appeared outside the commit step");

    a_commit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.commit && stat.out_busy) |=> ctl.commit)
        else $error("commit step left while the output register was held");

endmodule

// File: hw/rtl/mbq_regs.sv
// Configuration register file on the APB-style port: coefficients and channel count.
// Depends on mbq_pkg for the register map and the t_cfg bundle.

module mbq_regs import mbq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_go;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_go   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.b0     <= 32'h0100_0000;
            r_cfg.b1     <= '0;
            r_cfg.b2     <= '0;
            r_cfg.a1     <= '0;
            r_cfg.a2     <= '0;
            r_cfg.active <= ACTIVE_W'(2);
        end else if (wr_go) begin
            unique case (reg_idx)
                REG_B0:     r_cfg.b0     <= pwdata;
                REG_B1:     r_cfg.b1     <= pwdata;
                REG_B2:     r_cfg.b2     <= pwdata;
                REG_A1:     r_cfg.a1     <= pwdata;
                REG_A2:     r_cfg.a2     <= pwdata;
                REG_ACTIVE: r_cfg.active <= pwdata[ACTIVE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_B0:     prdata = r_cfg.b0;
            REG_B1:     prdata = r_cfg.b1;
            REG_B2:     prdata = r_cfg.b2;
            REG_A1:     prdata = r_cfg.a1;
            REG_A2:     prdata = r_cfg.a2;
            REG_ACTIVE: prdata = APB_DATA_W'(r_cfg.active);
            default:    prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/mbq_seq.sv
// Microcode sequencer: step counter, control-word lookup and conditional jumps.
// Depends on mbq_pkg for the control word, status bundle and microprogram.

module mbq_seq import mbq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    logic              take_jump;
    t_ctl              ctl;

    assign ctl   = mbq_ucode(r_pc);
    assign o_ctl = ctl;

    always_comb begin
        unique case (ctl.cond)
            COND_NEVER:    take_jump = 1'b0;
            COND_NO_ITEM:  take_jump = !i_stat.start;
            COND_OUT_BUSY: take_jump = i_stat.out_busy;
            default:       take_jump = 1'b0;
        endcase
        // the last step falls through to the wait step by wrapping
        n_pc = take_jump ? ctl.target : STEP_W'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: hw/rtl/mbq_datapath.sv
// Datapath: shared multiplier, accumulator, delay-state memory, channel position
// and output register, all steered by the control word. Depends on mbq_pkg.

module mbq_datapath import mbq_pkg::*; #(
    parameter  int CHANNELS     = 8,
    parameter  int SAMPLE_WIDTH = 24,
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_ctl                i_ctl,
    output t_stat               o_stat,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [TDATA_W-1:0]  i_s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
    input  logic                i_s_axis_tuser,   // [0] action
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [TDATA_W-1:0]  o_m_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
    output logic [CH_OUT_W-1:0] o_m_axis_tuser    // [2:0] channel
);

    localparam int PROD_W  = COEF_W + SAMPLE_WIDTH;
    localparam int RND_W   = PROD_W - COEF_FRAC;
    localparam int MAX_CNT = (1 << ACTIVE_W) - 1;
    localparam int CNT_CAP = (CHANNELS < MAX_CNT) ? CHANNELS : MAX_CNT;
    localparam int POS_W   = (CNT_CAP > 1) ? $clog2(CNT_CAP) : 1;
    localparam int ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic signed [ACC_W-1:0] Y_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (COEF_FRAC - 1));

    // handshake
    logic accepted;
    logic start;
    logic clear;
    logic out_busy;
    logic commit_go;

    assign o_s_axis_tready = i_ctl.accept;
    assign accepted        = i_s_axis_tvalid && i_ctl.accept;
    assign start           = accepted && !i_s_axis_tuser;
    assign clear           = accepted && i_s_axis_tuser;
    assign out_busy        = o_m_axis_tvalid && !i_m_axis_tready;
    assign commit_go       = i_ctl.commit && !out_busy;
    assign o_stat.start    = start;
    assign o_stat.out_busy = out_busy;

    // channel selection
    logic [ACTIVE_W-1:0] eff_count;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;
    logic [POS_W-1:0]    ch_cur;
    logic [POS_W-1:0]    r_ch;
    logic [ACTIVE_W-1:0] ch_inc;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;

    always_comb begin
        if (i_cfg.active == '0) begin
            eff_count = ACTIVE_W'(1);
        end else if (i_cfg.active > ACTIVE_W'(CNT_CAP)) begin
            eff_count = ACTIVE_W'(CNT_CAP);
        end else begin
            eff_count = i_cfg.active;
        end
        ch_cur = (ACTIVE_W'(r_pos) >= eff_count) ? '0 : r_pos;
        ch_inc = ACTIVE_W'(r_ch) + ACTIVE_W'(1);
        n_pos  = (ch_inc >= eff_count) ? '0 : POS_W'(ch_inc);
    end

    assign rd_addr = ADDR_W'(ch_cur);
    assign wr_addr = ADDR_W'(r_ch);

    // delay memory, {delay_two, delay_one} per channel
    logic [2*STATE_W-1:0] r_mem [CHANNELS];
    logic [2*STATE_W-1:0] r_rd;
    logic                 r_rd_valid;
    logic [CHANNELS-1:0]  r_valid;
    logic signed [STATE_W-1:0] d1_old;
    logic signed [STATE_W-1:0] d2_old;

    assign d1_old = r_rd_valid ? r_rd[STATE_W-1:0] : '0;
    assign d2_old = r_rd_valid ? r_rd[2*STATE_W-1:STATE_W] : '0;

    // multiplier
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic signed [COEF_W-1:0]       mul_a;
    logic signed [SAMPLE_WIDTH-1:0] mul_b;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [PROD_W-1:0]       prod_rnd;
    logic signed [RND_W-1:0]        rnd_term;

    always_comb begin
        unique case (i_ctl.mul_coef)
            COEF_B0: mul_a = i_cfg.b0;
            COEF_B1: mul_a = i_cfg.b1;
            COEF_B2: mul_a = i_cfg.b2;
            COEF_A1: mul_a = i_cfg.a1;
            COEF_A2: mul_a = i_cfg.a2;
            default: mul_a = '0;
        endcase
        unique case (i_ctl.mul_src)
            SRC_IN:  mul_b = i_s_axis_tdata[SAMPLE_WIDTH-1:0];
            SRC_X:   mul_b = r_x;
            SRC_Y:   mul_b = r_y;
            default: mul_b = '0;
        endcase
    end

    // round half up, drop the coefficient fraction
    assign prod_rnd = r_prod + RND_HALF;
    assign rnd_term = prod_rnd[PROD_W-1:COEF_FRAC];

    // accumulator and saturation
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [ACC_W-1:0]        n_acc;
    logic signed [ACC_W-1:0]        y_sum;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic signed [STATE_W-1:0]      r_d1;

    always_comb begin
        unique case (i_ctl.acc_op)
            ACC_HOLD:    n_acc = r_acc;
            ACC_LOAD:    n_acc = ACC_W'(rnd_term);
            ACC_LOAD_D2: n_acc = ACC_W'(rnd_term) + ACC_W'(d2_old);
            ACC_SUB:     n_acc = r_acc - ACC_W'(rnd_term);
        endcase
        y_sum = r_acc + ACC_W'(d1_old);
        if (y_sum > Y_MAX) begin
            y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
        end else if (y_sum < Y_MIN) begin
            y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            y_sat = y_sum[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_x        <= i_s_axis_tdata[SAMPLE_WIDTH-1:0];
            r_ch       <= ch_cur;
            r_rd       <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
        if (i_ctl.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        r_acc <= n_acc;
        if (i_ctl.y_en) begin
            r_y <= y_sat;
        end
        if (i_ctl.d1_en) begin
            r_d1 <= sat_state(r_acc);
        end
        if (commit_go) begin
            r_mem[wr_addr] <= {sat_state(r_acc), r_d1};
        end
    end

    // control state: valid bits, position, output register
    logic                       r_out_valid;
    logic [SAMPLE_WIDTH-1:0]    r_out_y;
    logic [CH_OUT_W-1:0]        r_out_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (clear) begin
                r_valid <= '0;
                r_pos   <= '0;
            end else if (commit_go) begin
                r_valid[wr_addr] <= 1'b1;
                r_pos            <= n_pos;
            end
            if (commit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_go) begin
            r_out_y  <= r_y;
            r_out_ch <= CH_OUT_W'(r_ch);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_out_y);
    assign o_m_axis_tuser  = r_out_ch;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for multichannel_biquad_df2t: a directed table, then random phases.
// Depends on mbq_pkg and the RTL of the filter; expected samples come from a local predictor.

module tb;
    import mbq_pkg::*;

    localparam int SW      = 24;
    localparam int NCH     = 8;
    localparam int TDW     = ((SW + 7) / 8) * 8;
    localparam int PHASES  = 10;
    localparam int PER_PHS = 150;
    localparam int SETTLE  = 20;

    typedef enum bit {
        ACT_FILTER = 1'b0,
        ACT_CLEAR  = 1'b1
    } t_action;

    typedef enum bit {
        ROW_WRITE = 1'b0,
        ROW_ITEM  = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        t_reg_idx       ridx;
        logic [31:0]    value;   // register value or input sample
        t_action        act;
        bit             typed;
        logic [SW-1:0]  exp_smp;
        logic [2:0]     exp_ch;
    } t_row;

    typedef struct packed {
        logic [SW-1:0] smp;
        logic [2:0]    ch;
    } t_filtered;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic [TDW-1:0]        s_data;
    logic                  s_user;
    logic                  m_valid;
    logic                  m_ready;
    logic [TDW-1:0]        m_data;
    logic [CH_OUT_W-1:0]   m_user;

    t_filtered   filtered_q[$];
    t_row        stim_rows[$];
    int          mismatches = 0;
    bit          quiet      = 1'b0;
    bit          hold_go    = 1'b0;
    bit          hold_done  = 1'b0;

    // Predictor state
    logic [31:0] coef_q[5];
    logic [3:0]  chan_count_q;
    longint      dly1[NCH];
    longint      dly2[NCH];
    int          chan_pos;

    multichannel_biquad_df2t #(
        .CHANNELS     (NCH),
        .SAMPLE_WIDTH (SW)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // [23:0] sample_in
        .i_s_axis_tuser  (s_user),    // [0] action
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // [23:0] sample_out
        .o_m_axis_tuser  (m_user)     // [2:0] channel
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %h, want %h", what, got, want);
        mismatches++;
    endtask

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Drop the 24 coefficient fraction bits, rounding half toward plus infinity.
    function automatic longint round_product(input logic [31:0] c, input longint x);
        longint cs;
        cs = $signed(c);
        return (cs * x + 64'sd8388608) >>> COEF_FRAC;
    endfunction

    task automatic predictor_reset();
        coef_q[0]    = 32'h0100_0000;
        coef_q[1]    = '0;
        coef_q[2]    = '0;
        coef_q[3]    = '0;
        coef_q[4]    = '0;
        chan_count_q = 4'd2;
        chan_pos     = 0;
        for (int i = 0; i < NCH; i++) begin
            dly1[i] = 0;
            dly2[i] = 0;
        end
    endtask

    // Returns 1 when the item yields a filtered sample.
    function automatic bit filter_predict(input t_action act, input logic [SW-1:0] smp,
                                          output t_filtered res);
        int     count;
        int     ch;
        longint x;
        longint y;
        longint n1;
        longint n2;
        res = '0;
        if (act == ACT_CLEAR) begin
            for (int i = 0; i < NCH; i++) begin
                dly1[i] = 0;
                dly2[i] = 0;
            end
            chan_pos = 0;
            return 1'b0;
        end
        count = chan_count_q;
        if (count == 0) count = 1;
        if (count > NCH) count = NCH;
        ch = (chan_pos >= count) ? 0 : chan_pos;
        x  = $signed(smp);
        y  = clamp(round_product(coef_q[REG_B0], x) + dly1[ch], SW);
        n1 = clamp(round_product(coef_q[REG_B1], x) - round_product(coef_q[REG_A1], y)
                   + dly2[ch], STATE_W);
        n2 = clamp(round_product(coef_q[REG_B2], x) - round_product(coef_q[REG_A2], y),
                   STATE_W);
        dly1[ch] = n1;
        dly2[ch] = n2;
        chan_pos = (ch + 1 >= count) ? 0 : ch + 1;
        res.smp  = y[SW-1:0];
        res.ch   = 3'(ch);
        return 1'b1;
    endfunction

    // Drop valid, wait for every expected sample, then let the block settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write one register over APB and read it back.
    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] val);
        logic [31:0] mask;
        wait_idle();
        mask = (idx == REG_ACTIVE) ? 32'h0000_000F : 32'hFFFF_FFFF;
        if (idx == REG_ACTIVE) chan_count_q = val[3:0];
        else coef_q[idx] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if ((prdata & mask) != (val & mask))
            flag_mismatch($sformatf("readback reg %0d", int'(idx)), prdata & mask, val & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one item, with random gaps, and record what it should produce.
    task automatic send_item(input t_action act, input logic [SW-1:0] smp, input bit typed,
                             input logic [SW-1:0] ys, input logic [2:0] yc);
        t_filtered res;
        while (!quiet && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= TDW'(smp);
        s_user  <= act;
        do @(posedge i_clk); while (!s_ready);
        if (filter_predict(act, smp, res)) begin
            if (typed) begin
                res.smp = ys;
                res.ch  = yc;
            end
            filtered_q.push_back(res);
        end
    endtask

    task automatic row_write(input t_reg_idx idx, input logic [31:0] val);
        t_row r;
        r       = '0;
        r.kind  = ROW_WRITE;
        r.ridx  = idx;
        r.value = val;
        stim_rows.push_back(r);
    endtask

    task automatic row_item(input t_action act, input logic [SW-1:0] smp, input bit typed,
                            input logic [SW-1:0] ys, input logic [2:0] yc);
        t_row r;
        r         = '0;
        r.kind    = ROW_ITEM;
        r.act     = act;
        r.value   = 32'(smp);
        r.typed   = typed;
        r.exp_smp = ys;
        r.exp_ch  = yc;
        stim_rows.push_back(r);
    endtask

    task automatic build_table();
        // After reset b0 is 1.0 and two channels alternate: samples pass unchanged.
        row_item(ACT_FILTER, 24'h7FFFFF, 1, 24'h7FFFFF, 3'd0);
        row_item(ACT_FILTER, 24'h800000, 1, 24'h800000, 3'd1);
        row_item(ACT_FILTER, 24'h000001, 1, 24'h000001, 3'd0);
        row_item(ACT_FILTER, 24'hFFFFFF, 1, 24'hFFFFFF, 3'd1);
        row_item(ACT_FILTER, 24'h000000, 1, 24'h000000, 3'd0);
        // Clear restarts at channel zero.
        row_item(ACT_CLEAR,  24'h000000, 0, '0, '0);
        row_item(ACT_FILTER, 24'h123456, 1, 24'h123456, 3'd0);
        // Zero count acts as one; position one wraps first.
        row_write(REG_ACTIVE, 32'd0);
        row_item(ACT_FILTER, 24'h400000, 1, 24'h400000, 3'd0);
        row_item(ACT_FILTER, 24'hC00000, 1, 24'hC00000, 3'd0);
        // Count above eight clamps to eight.
        row_write(REG_ACTIVE, 32'd15);
        row_item(ACT_FILTER, 24'h000100, 1, 24'h000100, 3'd0);
        row_item(ACT_FILTER, 24'h7FFF00, 1, 24'h7FFF00, 3'd1);
        row_item(ACT_FILTER, 24'hABCDEF, 1, 24'hABCDEF, 3'd2);
        // Position three is past a count of two.
        row_write(REG_ACTIVE, 32'd2);
        row_item(ACT_FILTER, 24'h0F0F0F, 1, 24'h0F0F0F, 3'd0);
        // Extreme gains saturate the output.
        row_write(REG_B0, 32'h7FFF_FFFF);
        row_item(ACT_FILTER, 24'h7FFFFF, 1, 24'h7FFFFF, 3'd1);
        row_item(ACT_FILTER, 24'h800000, 1, 24'h800000, 3'd0);
        row_write(REG_B0, 32'h8000_0000);
        row_item(ACT_FILTER, 24'h7FFFFF, 1, 24'h800000, 3'd1);
        row_item(ACT_FILTER, 24'h800000, 1, 24'h7FFFFF, 3'd0);
        // Extreme feedforward and feedback terms, then a count change over live state.
        row_write(REG_B1, 32'h7FFF_FFFF);
        row_write(REG_B2, 32'h8000_0000);
        row_write(REG_A1, 32'h8000_0000);
        row_write(REG_A2, 32'h7FFF_FFFF);
        row_write(REG_B0, 32'h0080_0000);
        row_item(ACT_FILTER, 24'h7FFFFF, 0, '0, '0);
        row_item(ACT_FILTER, 24'h800000, 0, '0, '0);
        row_item(ACT_FILTER, 24'h7FFFFF, 0, '0, '0);
        row_item(ACT_FILTER, 24'h800000, 0, '0, '0);
        row_item(ACT_FILTER, 24'hFFFFFF, 0, '0, '0);
        row_write(REG_ACTIVE, 32'd3);
        row_item(ACT_FILTER, 24'h7FFFFF, 0, '0, '0);
        row_item(ACT_FILTER, 24'h555555, 0, '0, '0);
    endtask

    function automatic logic [31:0] pick_coef();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) return 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
        if (roll < 70) return 32'(int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000);
        if (roll < 88) return $urandom;
        case ($urandom_range(4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0100_0000;
            default: return 32'hFF00_0000;
        endcase
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return SW'($urandom);
        if (roll < 85) return SW'(int'($urandom_range(0, 512)) - 256);
        case ($urandom_range(4))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'h000001;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off, and a stall-free stretch.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                m_ready  <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 26);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_filtered want;
        if (i_rst_n && m_valid && m_ready) begin
            if (filtered_q.size() == 0) begin
                flag_mismatch("result with nothing expected", 32'(m_data), '0);
            end else begin
                want = filtered_q.pop_front();
                if (m_data[SW-1:0] !== want.smp)
                    flag_mismatch("sample_out", 32'(m_data[SW-1:0]), 32'(want.smp));
                if (m_user !== want.ch)
                    flag_mismatch("channel", 32'(m_user), 32'(want.ch));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** multichannel_biquad_df2t: FAILED **");
        $finish;
    end

    initial begin
        t_row    r;
        t_action act;
        int      roll;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        s_valid = 1'b0;
        s_data  = '0;
        s_user  = 1'b0;
        predictor_reset();
        build_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            r = stim_rows[i];
            if (r.kind == ROW_WRITE) cfg_write(r.ridx, r.value);
            else send_item(r.act, r.value[SW-1:0], r.typed, r.exp_smp, r.exp_ch);
        end

        for (int p = 0; p < PHASES; p++) begin
            cfg_write(REG_B0, pick_coef());
            cfg_write(REG_B1, pick_coef());
            cfg_write(REG_B2, pick_coef());
            cfg_write(REG_A1, pick_coef());
            cfg_write(REG_A2, pick_coef());
            roll = $urandom_range(99);
            cfg_write(REG_ACTIVE, (roll < 65) ? $urandom_range(1, NCH) : $urandom_range(0, 15));
            quiet = (p == 5);
            if (p == 3) hold_go = 1'b1;
            for (int n = 0; n < PER_PHS; n++) begin
                act = ($urandom_range(99) < 4) ? ACT_CLEAR : ACT_FILTER;
                send_item(act, pick_sample(), 1'b0, '0, '0);
            end
        end
        quiet = 1'b0;

        wait_idle();
        if (mismatches == 0 && filtered_q.size() == 0) begin
            $display("** multichannel_biquad_df2t: PASSED **");
        end else begin
            $display("** multichannel_biquad_df2t: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mbq_pkg.sv
hw/rtl/mbq_regs.sv
hw/rtl/mbq_seq.sv
hw/rtl/mbq_datapath.sv
hw/rtl/multichannel_biquad_df2t.sv
bench/tb.sv
